>>> design/msp_pkg.sv
`default_nettype none

package msp_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int PAYLOAD_DEPTH = 2 * NUM_CHANNELS;
   localparam int CH_OUT = 4;
   localparam int PAY_SLOTS = (PAYLOAD_DEPTH > 2 * CH_OUT) ? PAYLOAD_DEPTH : 2 * CH_OUT;

   localparam logic [7:0] HDR_START = 8'h24;
   localparam logic [7:0] HDR_M = 8'h4D;
   localparam logic [7:0] HDR_DIR = 8'h3C;
   localparam logic [15:0] CHANNEL_RESET = 16'd1500;

   localparam logic [8:0] POS_HUNT = 9'd0;
   localparam logic [8:0] POS_M = 9'd1;
   localparam logic [8:0] POS_DIR = 9'd2;
   localparam logic [8:0] POS_LEN = 9'd3;
   localparam logic [8:0] POS_CMD = 9'd4;
   localparam logic [8:0] POS_DATA = 9'd5;

   localparam logic [7:0] SET_CH_RESET = 8'd200;
   localparam logic [7:0] ARM_RESET = 8'd201;
   localparam logic [7:0] DISARM_RESET = 8'd202;

   localparam int ADDR_W = 4;
   localparam logic [1:0] REG_SET_CH = 2'd0;
   localparam logic [1:0] REG_ARM = 2'd1;
   localparam logic [1:0] REG_DISARM = 2'd2;

   typedef logic [15:0] ch_type;
   typedef logic [7:0] byte_type;

endpackage

`default_nettype wire

>>> design/msp_frame_receiver.sv
`default_nettype none
// Latency: a frame's result is registered at the edge that accepts its checksum byte
// and shows on the rsp_ outputs in the next cycle.
// Throughput: one byte per cycle; the result register stalls input only while a
// result is held and rsp_ready is low.
// Reset (synchronous, active high): parser hunts for the start byte, channels 1500,
// disarmed, command codes 200/201/202.

module msp_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_command,
   output logic             rsp_checksum_ok,
   output logic [15:0]      rsp_throttle,
   output logic [15:0]      rsp_yaw,
   output logic [15:0]      rsp_pitch,
   output logic [15:0]      rsp_roll,
   output logic             rsp_armed,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [msp_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [7:0] set_ch_code_ff, arm_code_ff, disarm_code_ff;
   logic [8:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] chk_ff, chk_in;
   logic [7:0] cmd_ff, cmd_in;
   msp_pkg::byte_type pay_ff [msp_pkg::PAY_SLOTS];
   msp_pkg::byte_type pay_view [msp_pkg::PAY_SLOTS];
   msp_pkg::ch_type ch_ff [msp_pkg::CH_OUT];
   msp_pkg::ch_type ch_in [msp_pkg::CH_OUT];
   logic armed_ff, armed_in;

   logic rsp_valid_ff;
   logic [7:0] rsp_cmd_ff;
   logic rsp_ok_ff;
   msp_pkg::ch_type rsp_ch_ff [msp_pkg::CH_OUT];
   logic rsp_armed_ff;

   logic req_fire, in_frame, frame_done, sum_ok, pay_wr;
   logic [8:0] pay_offs;
   logic [1:0] reg_idx;
   logic cfg_wr;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;

   assign pready = 1'b1;
   assign reg_idx = paddr[3:2];
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      case (reg_idx)
         msp_pkg::REG_SET_CH: prdata = {24'd0, set_ch_code_ff};
         msp_pkg::REG_ARM:    prdata = {24'd0, arm_code_ff};
         msp_pkg::REG_DISARM: prdata = {24'd0, disarm_code_ff};
         default:             prdata = 32'd0;
      endcase
   end

   assign in_frame = pos_ff >= msp_pkg::POS_DATA;
   assign frame_done = in_frame && (pos_ff >= ({1'b0, len_ff} + msp_pkg::POS_DATA));
   assign sum_ok = req_rx_byte == chk_ff;
   assign pay_offs = pos_ff - msp_pkg::POS_DATA;
   assign pay_wr = in_frame && (pay_offs < 9'(msp_pkg::PAYLOAD_DEPTH));

   always_comb begin
      for (int k = 0; k < msp_pkg::PAY_SLOTS; k++) begin
         pay_view[k] = (pay_wr && pay_offs == 9'(k)) ? req_rx_byte : pay_ff[k];
      end
   end

   always_comb begin
      pos_in = pos_ff;
      len_in = len_ff;
      chk_in = chk_ff;
      cmd_in = cmd_ff;
      armed_in = armed_ff;
      for (int i = 0; i < msp_pkg::CH_OUT; i++) begin
         ch_in[i] = ch_ff[i];
      end
      case (pos_ff)
         msp_pkg::POS_HUNT: begin
            pos_in = (req_rx_byte == msp_pkg::HDR_START) ? msp_pkg::POS_M : msp_pkg::POS_HUNT;
         end
         msp_pkg::POS_M: begin
            pos_in = (req_rx_byte == msp_pkg::HDR_M) ? msp_pkg::POS_DIR : msp_pkg::POS_HUNT;
         end
         msp_pkg::POS_DIR: begin
            pos_in = (req_rx_byte == msp_pkg::HDR_DIR) ? msp_pkg::POS_LEN : msp_pkg::POS_HUNT;
         end
         msp_pkg::POS_LEN: begin
            len_in = req_rx_byte;
            chk_in = req_rx_byte;
            pos_in = msp_pkg::POS_CMD;
         end
         msp_pkg::POS_CMD: begin
            cmd_in = req_rx_byte;
            chk_in = chk_ff ^ req_rx_byte;
            pos_in = msp_pkg::POS_DATA;
         end
         default: begin
            if (frame_done) begin
               pos_in = msp_pkg::POS_HUNT;
               if (sum_ok) begin
                  if (cmd_ff == set_ch_code_ff) begin
                     for (int i = 0; i < msp_pkg::CH_OUT; i++) begin
                        if (i < msp_pkg::NUM_CHANNELS) begin
                           ch_in[i] = {pay_view[2 * i + 1], pay_view[2 * i]};
                        end
                     end
                  end else if (cmd_ff == arm_code_ff) begin
                     armed_in = 1'b1;
                  end else if (cmd_ff == disarm_code_ff) begin
                     armed_in = 1'b0;
                  end
               end
            end else begin
               chk_in = chk_ff ^ req_rx_byte;
               pos_in = pos_ff + 9'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ch_code_ff <= msp_pkg::SET_CH_RESET;
         arm_code_ff <= msp_pkg::ARM_RESET;
         disarm_code_ff <= msp_pkg::DISARM_RESET;
      end else if (cfg_wr) begin
         case (reg_idx)
            msp_pkg::REG_SET_CH: set_ch_code_ff <= pwdata[7:0];
            msp_pkg::REG_ARM:    arm_code_ff <= pwdata[7:0];
            msp_pkg::REG_DISARM: disarm_code_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= msp_pkg::POS_HUNT;
         len_ff <= 8'd0;
         chk_ff <= 8'd0;
         cmd_ff <= 8'd0;
         armed_ff <= 1'b0;
         for (int i = 0; i < msp_pkg::CH_OUT; i++) begin
            ch_ff[i] <= msp_pkg::CHANNEL_RESET;
         end
      end else if (req_fire) begin
         pos_ff <= pos_in;
         len_ff <= len_in;
         chk_ff <= chk_in;
         cmd_ff <= cmd_in;
         armed_ff <= armed_in;
         for (int i = 0; i < msp_pkg::CH_OUT; i++) begin
            ch_ff[i] <= ch_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && pay_wr) begin
         for (int k = 0; k < msp_pkg::PAY_SLOTS; k++) begin
            if (pay_offs == 9'(k)) begin
               pay_ff[k] <= req_rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && frame_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && frame_done) begin
         rsp_cmd_ff <= cmd_ff;
         rsp_ok_ff <= sum_ok;
         rsp_armed_ff <= armed_in;
         for (int i = 0; i < msp_pkg::CH_OUT; i++) begin
            rsp_ch_ff[i] <= ch_in[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_command = rsp_cmd_ff;
   assign rsp_checksum_ok = rsp_ok_ff;
   assign rsp_throttle = rsp_ch_ff[0];
   assign rsp_yaw = rsp_ch_ff[1];
   assign rsp_pitch = rsp_ch_ff[2];
   assign rsp_roll = rsp_ch_ff[3];
   assign rsp_armed = rsp_armed_ff;

`ifndef SYNTH
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      in_frame |-> pos_ff <= ({1'b0, len_ff} + msp_pkg::POS_DATA))
      else $error("position past end of frame");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && frame_done) |=> rsp_valid_ff && pos_ff == msp_pkg::POS_HUNT)
      else $error("completed frame did not register a result");

   a_bad_sum_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (req_fire && frame_done && !sum_ok) |=>
         $stable(armed_ff) && $stable(ch_ff[0]) && $stable(ch_ff[1])
         && $stable(ch_ff[2]) && $stable(ch_ff[3]))
      else $error("bad checksum changed channels or armed flag");
`endif

endmodule

`default_nettype wire
